// ===== rtl/csg_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubemap sky gradient package
// Shared types and fixed-point constants for the sky gradient texel pipeline.
// ----------------------------------------------------------------------------
package csg_pkg;

  // Texels along one face edge are 2**FACE_LOG2.
  localparam int FACE_LOG2   = 6;
  localparam int COORD_SHIFT = 16 - FACE_LOG2;

  // Q1.16 constants.
  localparam logic [16:0] ONE_Q   = 17'd65536;
  localparam logic [16:0] T_HI    = 17'd42598;
  localparam logic [16:0] T_LO    = 17'd22938;
  localparam logic [14:0] T_BAND  = 15'd22938;
  // floor-biased reciprocal of the band width, scaled by 2**32.
  localparam logic [17:0] RECIP_M = 18'd187242;

  localparam int SQRT_STEPS = 17;
  localparam int DIV_STEPS  = 17;

  // Configuration register indexes.
  localparam logic [1:0] REG_TOP     = 2'd0;
  localparam logic [1:0] REG_BOTTOM  = 2'd1;
  localparam logic [1:0] REG_HORIZON = 2'd2;

  // Face codes.
  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  typedef enum logic [1:0] {
    SEL_HORIZON,
    SEL_TOP,
    SEL_BOTTOM
  } sel_t;

  typedef struct packed {
    logic [2:0] face;
    logic [5:0] col;
    logic [5:0] row;
  } texel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } texel_out_t;

  typedef struct packed {
    logic [33:0] src;
    logic [16:0] mag;
    logic        neg;
  } norm_in_t;

  typedef struct packed {
    logic [16:0] quo;
    logic        neg;
  } norm_out_t;

endpackage

// ===== rtl/cubemap_sky_gradient_texel.sv =====
// ----------------------------------------------------------------------------
// Cubemap sky gradient texel generator
// Turns a face/column/row address into a sky gradient colour.
// ----------------------------------------------------------------------------
// The block takes one texel address per clock unless stalled; a texel moves
// through three setup stages, a 17-stage square root, a 17-stage divider and
// seven blend and output stages. The whole pipeline holds while the output
// register is full and stalled, so in_stall follows out_stall whenever a
// result waits. There is no start-up sweep.
module cubemap_sky_gradient_texel (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  csg_pkg::texel_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output csg_pkg::texel_out_t out_data
);

  logic [23:0] top_color;
  logic [23:0] bottom_color;
  logic [23:0] horizon_color;
  logic        en;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_color     <= 24'h193399;
      bottom_color  <= 24'h664D33;
      horizon_color <= 24'h7FB2E5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csg_pkg::REG_TOP:     top_color     <= cfg_data;
        csg_pkg::REG_BOTTOM:  bottom_color  <= cfg_data;
        csg_pkg::REG_HORIZON: horizon_color <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: texel-centre coordinates as magnitudes.
  logic [16:0] acol;
  logic [16:0] arow;
  logic [15:0] abs_u_c;
  logic [15:0] abs_v_c;
  logic [16:0] mag_c;
  logic        neg_c;

  assign acol    = 17'({in_data.col, 1'b1}) << csg_pkg::COORD_SHIFT;
  assign arow    = 17'({in_data.row, 1'b1}) << csg_pkg::COORD_SHIFT;
  assign abs_u_c = acol[16] ? 16'(acol - csg_pkg::ONE_Q) : 16'(csg_pkg::ONE_Q - acol);
  assign abs_v_c = arow[16] ? 16'(arow - csg_pkg::ONE_Q) : 16'(csg_pkg::ONE_Q - arow);

  always_comb begin
    unique case (in_data.face)
      csg_pkg::FACE_PY: begin
        mag_c = csg_pkg::ONE_Q;
        neg_c = 1'b0;
      end
      csg_pkg::FACE_NY: begin
        mag_c = csg_pkg::ONE_Q;
        neg_c = 1'b1;
      end
      csg_pkg::FACE_PX, csg_pkg::FACE_NX, csg_pkg::FACE_PZ, csg_pkg::FACE_NZ: begin
        // The vertical component is -v on the side faces.
        mag_c = {1'b0, abs_v_c};
        neg_c = arow[16];
      end
      default: begin
        mag_c = '0;
        neg_c = 1'b0;
      end
    endcase
  end

  logic        v1;
  logic [15:0] abs_u1;
  logic [15:0] abs_v1;
  logic [16:0] mag1;
  logic        neg1;

  // Stage 2: squares.
  logic        v2;
  logic [15:0] uu2;
  logic [15:0] vv2;
  logic [16:0] mag2;
  logic        neg2;
  logic [31:0] uprod;
  logic [31:0] vprod;

  assign uprod = abs_u1 * abs_u1;
  assign vprod = abs_v1 * abs_v1;

  // Stage 3: squared length, scaled for the root.
  logic              v3;
  csg_pkg::norm_in_t norm_in;
  logic [17:0]       sq_sum;

  assign sq_sum = 18'(csg_pkg::ONE_Q) + 18'(uu2) + 18'(vv2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_u1       <= abs_u_c;
      abs_v1       <= abs_v_c;
      mag1         <= mag_c;
      neg1         <= neg_c;
      uu2          <= uprod[31:16];
      vv2          <= vprod[31:16];
      mag2         <= mag1;
      neg2         <= neg1;
      norm_in.src  <= {sq_sum, 16'd0};
      norm_in.mag  <= mag2;
      norm_in.neg  <= neg2;
    end
  end

  logic               vn;
  csg_pkg::norm_out_t norm_out;

  csg_dirnorm u_dirnorm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_data   (norm_in),
    .out_valid (vn),
    .out_data  (norm_out)
  );

  // Stage T: gradient parameter t in 0..1.
  logic [17:0] t_sum;
  logic        vt;
  logic [16:0] t_q;

  assign t_sum = norm_out.neg ? 18'(csg_pkg::ONE_Q) - 18'(norm_out.quo)
                              : 18'(csg_pkg::ONE_Q) + 18'(norm_out.quo);

  // Stage D: distance into the blend band and which colour it moves toward.
  logic          vd;
  logic [14:0]   d_c;
  csg_pkg::sel_t sel_c;
  logic [14:0]   dist_d;
  csg_pkg::sel_t sel_d;

  always_comb begin
    priority if (t_q > csg_pkg::T_HI) begin
      d_c   = 15'(t_q - csg_pkg::T_HI);
      sel_c = csg_pkg::SEL_TOP;
    end else if (t_q < csg_pkg::T_LO) begin
      d_c   = 15'(csg_pkg::T_LO - t_q);
      sel_c = csg_pkg::SEL_BOTTOM;
    end else begin
      d_c   = '0;
      sel_c = csg_pkg::SEL_HORIZON;
    end
  end

  // Stage M: reciprocal multiply. Stage R: remainder. Stage B: corrected blend.
  logic          vm;
  logic [32:0]   recip_m;
  logic [14:0]   dist_m;
  csg_pkg::sel_t sel_m;

  logic          vr;
  logic [16:0]   q0_c;
  logic [31:0]   back_c;
  logic [31:0]   rem_c;
  logic [16:0]   q0_r;
  logic [15:0]   rem_r;
  csg_pkg::sel_t sel_r;

  logic          vb;
  logic [16:0]   blend_b;
  csg_pkg::sel_t sel_b;

  assign q0_c   = recip_m[32:16];
  assign back_c = 32'(q0_c) * 32'(csg_pkg::T_BAND);
  assign rem_c  = {1'b0, dist_m, 16'd0} - back_c;

  // Stage X: weighted sum per channel.
  logic          vx;
  logic [23:0]   other_c;
  logic [16:0]   inv_blend;
  logic [24:0]   mix_c [0:2];
  logic [24:0]   mix_x [0:2];
  logic [7:0]    chan  [0:2];

  always_comb begin
    unique case (sel_b)
      csg_pkg::SEL_TOP:    other_c = top_color;
      csg_pkg::SEL_BOTTOM: other_c = bottom_color;
      default:             other_c = horizon_color;
    endcase
  end

  assign inv_blend = csg_pkg::ONE_Q - blend_b;

  for (genvar c = 0; c < 3; c++) begin : g_mix
    assign mix_c[c] = 25'(horizon_color[c*8 +: 8]) * 25'(inv_blend)
                    + 25'(other_c[c*8 +: 8]) * 25'(blend_b);
    assign chan[c]  = (mix_x[c][24:16] > 9'd255) ? 8'd255 : mix_x[c][23:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vt        <= 1'b0;
      vd        <= 1'b0;
      vm        <= 1'b0;
      vr        <= 1'b0;
      vb        <= 1'b0;
      vx        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vt        <= vn;
      vd        <= vt;
      vm        <= vd;
      vr        <= vm;
      vb        <= vr;
      vx        <= vb;
      out_valid <= vx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_q            <= t_sum[17:1];
      dist_d         <= d_c;
      sel_d          <= sel_c;
      recip_m        <= dist_d * csg_pkg::RECIP_M;
      dist_m         <= dist_d;
      sel_m          <= sel_d;
      q0_r           <= q0_c;
      rem_r          <= rem_c[15:0];
      sel_r          <= sel_m;
      blend_b        <= q0_r + 17'(rem_r >= 16'(csg_pkg::T_BAND));
      sel_b          <= sel_r;
      mix_x[0]       <= mix_c[0];
      mix_x[1]       <= mix_c[1];
      mix_x[2]       <= mix_c[2];
      out_data.red   <= chan[2];
      out_data.green <= chan[1];
      out_data.blue  <= chan[0];
    end
  end

endmodule

// ===== rtl/csg_dirnorm.sv =====
// ----------------------------------------------------------------------------
// Direction normaliser
// Pipelined square root of the squared length, then a pipelined restoring
// divide of the vertical magnitude by that length, one bit per stage.
// ----------------------------------------------------------------------------
module csg_dirnorm (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  csg_pkg::norm_in_t  in_data,
  output logic               out_valid,
  output csg_pkg::norm_out_t out_data
);

  typedef struct packed {
    logic [17:0] rem;
    logic [16:0] root;
    logic [33:0] src;
    logic [16:0] mag;
    logic        neg;
  } sq_stage_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [16:0] num;
    logic [16:0] quo;
    logic [16:0] den;
    logic        neg;
  } dv_stage_t;

  sq_stage_t sqs [0:csg_pkg::SQRT_STEPS];
  logic      sqv [0:csg_pkg::SQRT_STEPS];
  dv_stage_t dvs [0:csg_pkg::DIV_STEPS];
  logic      dvv [0:csg_pkg::DIV_STEPS];

  assign sqs[0] = '{rem: '0, root: '0, src: in_data.src, mag: in_data.mag,
                    neg: in_data.neg};
  assign sqv[0] = in_valid;

  // Square root, two radicand bits per stage.
  for (genvar k = 0; k < csg_pkg::SQRT_STEPS; k++) begin : g_sqrt
    logic [19:0] rsh;
    logic [19:0] trial;
    logic [19:0] diff;
    logic        ge;
    sq_stage_t   nxt;

    assign rsh   = {sqs[k].rem, sqs[k].src[33:32]};
    assign trial = {1'b0, sqs[k].root, 2'b01};
    assign diff  = rsh - trial;
    assign ge    = (rsh >= trial);

    always_comb begin
      nxt      = sqs[k];
      nxt.rem  = ge ? diff[17:0] : rsh[17:0];
      nxt.root = {sqs[k].root[15:0], ge};
      nxt.src  = {sqs[k].src[31:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[k+1] <= 1'b0;
      end else if (en) begin
        sqv[k+1] <= sqv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sqs[k+1] <= nxt;
      end
    end
  end

  // The numerator is mag << 16; its top 16 bits are already below the divisor.
  assign dvs[0] = '{rem: {1'b0, sqs[csg_pkg::SQRT_STEPS].mag[16:1]},
                    num: {sqs[csg_pkg::SQRT_STEPS].mag[0], 16'd0},
                    quo: '0,
                    den: sqs[csg_pkg::SQRT_STEPS].root,
                    neg: sqs[csg_pkg::SQRT_STEPS].neg};
  assign dvv[0] = sqv[csg_pkg::SQRT_STEPS];

  for (genvar k = 0; k < csg_pkg::DIV_STEPS; k++) begin : g_div
    logic [17:0] rsh;
    logic [17:0] diff;
    logic        ge;
    dv_stage_t   nxt;

    assign rsh  = {dvs[k].rem, dvs[k].num[16]};
    assign diff = rsh - {1'b0, dvs[k].den};
    assign ge   = (rsh >= {1'b0, dvs[k].den});

    always_comb begin
      nxt     = dvs[k];
      nxt.rem = ge ? diff[16:0] : rsh[16:0];
      nxt.num = {dvs[k].num[15:0], 1'b0};
      nxt.quo = {dvs[k].quo[15:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (en) begin
        dvv[k+1] <= dvv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvs[k+1] <= nxt;
      end
    end
  end

  assign out_valid    = dvv[csg_pkg::DIV_STEPS];
  assign out_data.quo = dvs[csg_pkg::DIV_STEPS].quo;
  assign out_data.neg = dvs[csg_pkg::DIV_STEPS].neg;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Sky gradient texel generator testbench
// Sends texel addresses through the valid/stall input channel and predicts
// each colour in fixed point. It checks every output transfer against the
// oldest prediction. Several colour settings are used, with idle and stall
// phases, and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = csg_pkg::REG_TOP;
  logic [23:0]         cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  csg_pkg::texel_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  csg_pkg::texel_out_t out_data;

  cubemap_sky_gradient_texel dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  csg_pkg::texel_in_t  pending_texels[$];
  csg_pkg::texel_out_t expected_colours[$];
  logic [23:0] top_rgb = 24'h193399;
  logic [23:0] bottom_rgb = 24'h664D33;
  logic [23:0] horizon_rgb = 24'h7FB2E5;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  bit hold_off_req = 0;
  bit hold_off_done = 0;
  int hold_off_left = 0;

  function automatic longint unsigned floor_sqrt(longint unsigned val);
    longint unsigned root = 0;
    longint unsigned step = 64'd1 << 62;
    while (step > val) step >>= 2;
    while (step != 0) begin
      if (val >= root + step) begin
        val -= root + step;
        root = (root >> 1) + step;
      end else begin
        root >>= 1;
      end
      step >>= 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] blend_channel(logic [7:0] h, logic [7:0] c,
                                               longint unsigned blend);
    longint unsigned mixed;
    mixed = (longint'(h) * (65536 - blend) + longint'(c) * blend) >> 16;
    return (mixed > 255) ? 8'd255 : mixed[7:0];
  endfunction

  function automatic csg_pkg::texel_out_t sky_colour(csg_pkg::texel_in_t txl);
    longint u, v, dyn;
    longint unsigned uu, vv, len, mag, quo, t, blend;
    bit neg;
    logic [23:0] other;
    csg_pkg::texel_out_t res;
    u = longint'(2 * txl.col + 1) * 1024 - 65536;
    v = longint'(2 * txl.row + 1) * 1024 - 65536;
    uu = (u * u) >> 16;
    vv = (v * v) >> 16;
    len = floor_sqrt((65536 + uu + vv) << 16);
    if (len == 0) len = 1;
    neg = 0;
    mag = 0;
    case (txl.face)
      csg_pkg::FACE_PY: mag = 65536;
      csg_pkg::FACE_NY: begin
        mag = 65536;
        neg = 1;
      end
      csg_pkg::FACE_PX, csg_pkg::FACE_NX, csg_pkg::FACE_PZ, csg_pkg::FACE_NZ: begin
        neg = v > 0;
        mag = (v < 0) ? -v : v;
      end
      default: mag = 0;  // undefined faces sit on the horizon
    endcase
    quo = (mag << 16) / len;
    dyn = neg ? -longint'(quo) : longint'(quo);
    t = longint'(dyn + 65536) >> 1;
    blend = 0;
    other = horizon_rgb;
    if (t > csg_pkg::T_HI) begin
      blend = ((t - csg_pkg::T_HI) << 16) / csg_pkg::T_BAND;
      other = top_rgb;
    end else if (t < csg_pkg::T_LO) begin
      blend = ((csg_pkg::T_LO - t) << 16) / csg_pkg::T_BAND;
      other = bottom_rgb;
    end
    if (blend > 65536) blend = 65536;
    res.red   = blend_channel(horizon_rgb[23:16], other[23:16], blend);
    res.green = blend_channel(horizon_rgb[15:8], other[15:8], blend);
    res.blue  = blend_channel(horizon_rgb[7:0], other[7:0], blend);
    return res;
  endfunction

  // Sender: a new texel is offered only once the previous one has transferred.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_colours.push_back(sky_colour(in_data));
      if (pending_texels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_texels.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long output hold-off, counted down once it has been requested.
  always @(posedge clk) begin
    if (hold_off_req && !hold_off_done) begin
      hold_off_done <= 1'b1;
      hold_off_left <= 300;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  // Receiver: checks each output transfer and chooses the next stall.
  always @(posedge clk) begin
    csg_pkg::texel_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_colours.size() == 0) begin
        errors++;
        $display("%0t: unexpected texel, expected none, actual %h", $time, out_data);
      end else begin
        want = expected_colours.pop_front();
        if (out_data.red !== want.red)
          $display("%0t: red mismatch, expected %h, actual %h", $time, want.red, out_data.red);
        if (out_data.green !== want.green)
          $display("%0t: green mismatch, expected %h, actual %h",
                   $time, want.green, out_data.green);
        if (out_data.blue !== want.blue)
          $display("%0t: blue mismatch, expected %h, actual %h",
                   $time, want.blue, out_data.blue);
        if (out_data !== want) errors++;
      end
    end
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic drain();
    while (pending_texels.size() > 0 || in_valid || expected_colours.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      csg_pkg::REG_TOP: top_rgb = val;
      csg_pkg::REG_BOTTOM: bottom_rgb = val;
      csg_pkg::REG_HORIZON: horizon_rgb = val;
      default: ;  // writes to an unknown index are dropped
    endcase
  endtask

  task automatic queue_random(int count);
    csg_pkg::texel_in_t txl;
    repeat (count) begin
      txl.face = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
      txl.col = 6'($urandom_range(0, 63));
      txl.row = 6'($urandom_range(0, 63));
      pending_texels.push_back(txl);
    end
  endtask

  initial begin
    csg_pkg::texel_in_t txl;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // Directed corners and centre on every face code, including undefined ones.
    for (int f = 0; f < 8; f++) begin
      txl.face = 3'(f);
      txl.col = 6'd0;  txl.row = 6'd0;  pending_texels.push_back(txl);
      txl.col = 6'd63; txl.row = 6'd63; pending_texels.push_back(txl);
      txl.col = 6'd31; txl.row = 6'd32; pending_texels.push_back(txl);
    end
    drain();
    write_reg(csg_pkg::REG_TOP, 24'hFFFFFF);
    write_reg(csg_pkg::REG_BOTTOM, 24'h000000);
    write_reg(csg_pkg::REG_HORIZON, 24'h000000);
    queue_random(370);
    drain();
    write_reg(csg_pkg::REG_TOP, 24'h000000);
    write_reg(csg_pkg::REG_BOTTOM, 24'hFFFFFF);
    write_reg(csg_pkg::REG_HORIZON, 24'hFFFFFF);
    send_idle_pct = 51;
    queue_random(370);
    drain();
    write_reg(csg_pkg::REG_TOP, 24'($urandom));
    write_reg(csg_pkg::REG_BOTTOM, 24'($urandom));
    write_reg(csg_pkg::REG_HORIZON, 24'($urandom));
    write_reg(2'd3, 24'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 51;
    queue_random(370);
    drain();
    write_reg(csg_pkg::REG_TOP, 24'($urandom));
    write_reg(csg_pkg::REG_HORIZON, 24'($urandom));
    send_idle_pct = 12;
    recv_stall_pct = 12;
    queue_random(370);
    drain();
    write_reg(csg_pkg::REG_BOTTOM, 24'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // The long output hold-off fills the pipeline while texels keep coming.
    hold_off_req = 1'b1;
    queue_random(346);
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
